>>> src/rvig_pkg.sv
// Shared widths and reset constants for the radial vignette pixel unit.
// No dependencies; every module of the unit imports this package.
package rvig_pkg;

  // Largest frame edge the coordinate ports can address
  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned COORD_W   = $clog2(MaxDim);          // pixel coordinate
  localparam int unsigned DIM_W     = COORD_W + 1;             // frame size register
  localparam int unsigned CH_W      = 8;                       // one colour channel
  localparam int unsigned PIX_W     = 3 * CH_W;                // blue, green, red
  localparam int unsigned CFG_IDX_W = 2;

  // Distance datapath
  localparam int unsigned FRAC_W    = 8;                       // fraction bits of distance
  localparam int unsigned SQ_W      = 2 * COORD_W + 1;         // dr^2 + dc^2
  localparam int unsigned ROOT_IN_W = SQ_W + 2 * FRAC_W;       // radicand
  localparam int unsigned ROOT_W    = (ROOT_IN_W + 1) / 2;     // distance, 8 fraction bits
  localparam int unsigned SUM_W     = DIM_W + 1;               // rows + cols

  // Gain datapath: 512 * rows * cols and d * (rows + cols) share one width
  localparam int unsigned NORM_SH   = FRAC_W + 1;
  localparam int unsigned NORM_W    = 2 * DIM_W + NORM_SH;
  localparam int unsigned PROD_W    = ROOT_W + SUM_W;
  localparam int unsigned GAIN_FRAC = 16;
  localparam int unsigned GAIN_W    = GAIN_FRAC + 1;           // Q1.16, never above 1.0

  localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(1024);
  localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(1024);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    RegFrameRows = CFG_IDX_W'(0),
    RegFrameCols = CFG_IDX_W'(1)
  } cfg_reg_e;

endpackage

>>> src/rvig_isqrt.sv
// Pipelined integer square root, floored, one result bit per stage.
// Depends on rvig_pkg; a side word travels alongside each request.
module rvig_isqrt
  import rvig_pkg::*;
#(
  parameter int unsigned IN_W  = ROOT_IN_W,
  parameter int unsigned TAG_W = PIX_W,
  localparam int unsigned RES_W = (IN_W + 1) / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [IN_W-1:0]  rad_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [RES_W-1:0] root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned TRY_W = 2 * RES_W + 1;

  logic [IN_W-1:0]  rem_q  [RES_W];
  logic [RES_W-1:0] root_q [RES_W];
  logic [TAG_W-1:0] tag_q  [RES_W];
  logic [RES_W-1:0] vld_q;

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    localparam int unsigned Pos = RES_W - 1 - k;

    logic [IN_W-1:0]  rem_in;
    logic [RES_W-1:0] root_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [TRY_W-1:0] trial;
    logic             take;
    logic [IN_W-1:0]  rem_d;
    logic [RES_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (root + 2^pos)^2 <= v  <=>  v - root^2 >= root * 2^(pos+1) + 2^(2 pos)
    assign trial  = (TRY_W'(root_in) << (Pos + 1)) + (TRY_W'(1) << (2 * Pos));
    assign take   = TRY_W'(rem_in) >= trial;
    assign rem_d  = take ? rem_in - trial[IN_W-1:0] : rem_in;
    assign root_d = take ? (root_in | (RES_W'(1) << Pos)) : root_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[RES_W-1];
  assign root_o  = root_q[RES_W-1];
  assign tag_o   = tag_q[RES_W-1];

endmodule

>>> src/rvig_div.sv
// Pipelined restoring divider: quotient of (num << (Q_W-1)) / den, one bit per stage.
// Depends on rvig_pkg; num must not exceed den, and den holds while requests are in flight.
module rvig_div
  import rvig_pkg::*;
#(
  parameter int unsigned DEN_W = NORM_W,
  parameter int unsigned Q_W   = GAIN_W,
  parameter int unsigned TAG_W = PIX_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [DEN_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]   quot_q [Q_W];
  logic [TAG_W-1:0] tag_q  [Q_W];
  logic [Q_W-1:0]   vld_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned Pos = Q_W - 1 - k;

    logic [DEN_W:0]   rem_in;
    logic [Q_W-1:0]   quot_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic             take;
    logic [DEN_W:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign quot_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      // remainder stays below den, so one more bit holds the shift
      assign rem_in  = {rem_q[k-1], 1'b0};
      assign quot_in = quot_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign diff = rem_in - {1'b0, den_i};
    assign take = rem_in >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DEN_W-1:0] : rem_in[DEN_W-1:0];
        quot_q[k] <= take ? (quot_in | (Q_W'(1) << Pos)) : quot_in;
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

>>> src/rvig_obuf.sv
// Output register with a skid entry, decoupling the pipeline from output back-pressure.
// Depends on rvig_pkg; drives the pipeline advance enable.
module rvig_obuf
  import rvig_pkg::*;
#(
  parameter int unsigned W = PIX_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         en_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic         out_v_q;
  logic         skid_v_q;
  logic [W-1:0] out_data_q;
  logic [W-1:0] skid_data_q;
  logic         out_free;

  assign out_free = !out_v_q || out_ready_i;
  // pipeline advances only while the skid entry is empty
  assign en_o     = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= valid_i;
      end
    end else if (valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_v_q ? skid_data_q : data_i;
    end else if (!skid_v_q) begin
      skid_data_q <= data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/radial_vignette_pixel_unit.sv
// Radial vignette on one BGR pixel: top level with config registers and pipeline stages.
// Depends on rvig_pkg, rvig_isqrt, rvig_div and rvig_obuf.
//
//   port group  | dir | handshake              | payload
//   ------------+-----+------------------------+-------------------------------------
//   cfg         | in  | cfg_valid_i/ready_o    | cfg_index_i, cfg_data_i
//   in          | in  | in_valid_i/in_ready_o  | pixel_row_i, pixel_col_i, *_in_i
//   out         | out | out_valid_o/ready_i    | blue_out_o, green_out_o, red_out_o
//
// One pixel per clock sustained while the skid entry is empty; each request passes S0 to S3,
// the 21-stage square root, M1, M2, the 17-stage gain divider, C1 and the output register.
// Reset sets both frame sizes to 1024 and empties the pipeline.
// The output register and its skid entry absorb back-pressure: the pipeline keeps
// advancing until the skid entry fills, then every stage holds.
module radial_vignette_pixel_unit
  import rvig_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COORD_W-1:0]   pixel_row_i,
  input  logic [COORD_W-1:0]   pixel_col_i,
  input  logic [CH_W-1:0]      blue_in_i,
  input  logic [CH_W-1:0]      green_in_i,
  input  logic [CH_W-1:0]      red_in_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CH_W-1:0]      blue_out_o,
  output logic [CH_W-1:0]      green_out_o,
  output logic [CH_W-1:0]      red_out_o
);

  localparam logic [NORM_W-1:0] NORM_RST =
      {NORM_W'(ROWS_RST) * NORM_W'(COLS_RST)} << NORM_SH;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0]   rows_q, cols_q;
  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [COORD_W-1:0] half_r, half_c;
  logic [2*DIM_W-1:0] area;
  logic [NORM_W-1:0]  norm_q;
  logic [SUM_W-1:0]   sum_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFrameRows: rows_q <= cfg_data_i;
        RegFrameCols: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero frame size acts as one
  assign rows_eff = (rows_q == '0) ? DIM_W'(1) : rows_q;
  assign cols_eff = (cols_q == '0) ? DIM_W'(1) : cols_q;
  assign half_r   = rows_eff[DIM_W-1:1];
  assign half_c   = cols_eff[DIM_W-1:1];
  assign area     = {{DIM_W{1'b0}}, rows_eff} * {{DIM_W{1'b0}}, cols_eff};

  // derived frame terms, used many stages after entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= NORM_RST;
      sum_q  <= SUM_W'(ROWS_RST) + SUM_W'(COLS_RST);
    end else begin
      norm_q <= {area, {NORM_SH{1'b0}}};
      sum_q  <= {1'b0, rows_eff} + {1'b0, cols_eff};
    end
  end

  // ---------------- pipeline control ----------------
  logic pipe_en;

  assign in_ready_o = pipe_en;

  // ---------------- S0: capture request ----------------
  logic               vld_s0_q;
  logic [COORD_W-1:0] row_s0_q, col_s0_q;
  logic [PIX_W-1:0]   pix_s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s0_q <= 1'b0;
    end else if (pipe_en) begin
      vld_s0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      row_s0_q <= pixel_row_i;
      col_s0_q <= pixel_col_i;
      pix_s0_q <= {blue_in_i, green_in_i, red_in_i};
    end
  end

  // ---------------- S1: distance to centre per axis ----------------
  logic [COORD_W:0]   diff_r, diff_c, neg_r, neg_c;
  logic [COORD_W-1:0] abs_r, abs_c;
  logic               vld_s1_q;
  logic [COORD_W-1:0] adr_s1_q, adc_s1_q;
  logic [PIX_W-1:0]   pix_s1_q;

  assign diff_r = {1'b0, row_s0_q} - {1'b0, half_r};
  assign diff_c = {1'b0, col_s0_q} - {1'b0, half_c};
  assign neg_r  = '0 - diff_r;
  assign neg_c  = '0 - diff_c;
  assign abs_r  = diff_r[COORD_W] ? neg_r[COORD_W-1:0] : diff_r[COORD_W-1:0];
  assign abs_c  = diff_c[COORD_W] ? neg_c[COORD_W-1:0] : diff_c[COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s1_q <= 1'b0;
    end else if (pipe_en) begin
      vld_s1_q <= vld_s0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      adr_s1_q <= abs_r;
      adc_s1_q <= abs_c;
      pix_s1_q <= pix_s0_q;
    end
  end

  // ---------------- S2: squares ----------------
  logic                 vld_s2_q;
  logic [2*COORD_W-1:0] sqr_s2_q, sqc_s2_q;
  logic [PIX_W-1:0]     pix_s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s2_q <= 1'b0;
    end else if (pipe_en) begin
      vld_s2_q <= vld_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sqr_s2_q <= {{COORD_W{1'b0}}, adr_s1_q} * {{COORD_W{1'b0}}, adr_s1_q};
      sqc_s2_q <= {{COORD_W{1'b0}}, adc_s1_q} * {{COORD_W{1'b0}}, adc_s1_q};
      pix_s2_q <= pix_s1_q;
    end
  end

  // ---------------- S3: squared radius ----------------
  logic              vld_s3_q;
  logic [SQ_W-1:0]   sq_s3_q;
  logic [PIX_W-1:0]  pix_s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s3_q <= 1'b0;
    end else if (pipe_en) begin
      vld_s3_q <= vld_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sq_s3_q  <= {1'b0, sqr_s2_q} + {1'b0, sqc_s2_q};
      pix_s3_q <= pix_s2_q;
    end
  end

  // ---------------- square root: distance with 8 fraction bits ----------------
  logic              root_vld;
  logic [ROOT_W-1:0] root_d;
  logic [PIX_W-1:0]  root_pix;

  rvig_isqrt #(
    .IN_W  (ROOT_IN_W),
    .TAG_W (PIX_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vld_s3_q),
    .rad_i   ({sq_s3_q, {(2*FRAC_W){1'b0}}}),
    .tag_i   (pix_s3_q),
    .valid_o (root_vld),
    .root_o  (root_d),
    .tag_o   (root_pix)
  );

  // ---------------- M1: d * (rows + cols) ----------------
  logic              vld_m1_q;
  logic [PROD_W-1:0] prod_m1_q;
  logic [PIX_W-1:0]  pix_m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m1_q <= 1'b0;
    end else if (pipe_en) begin
      vld_m1_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_m1_q <= {{SUM_W{1'b0}}, root_d} * {{ROOT_W{1'b0}}, sum_q};
      pix_m1_q  <= root_pix;
    end
  end

  // ---------------- M2: numerator, zero where the gain would not be positive ----
  logic              vld_m2_q;
  logic [NORM_W-1:0] num_m2_q;
  logic [PIX_W-1:0]  pix_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m2_q <= 1'b0;
    end else if (pipe_en) begin
      vld_m2_q <= vld_m1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_m2_q <= (prod_m1_q < norm_q) ? norm_q - prod_m1_q : '0;
      pix_m2_q <= pix_m1_q;
    end
  end

  // ---------------- gain = num * 2^16 / (512 * rows * cols) ----------------
  logic              div_vld;
  logic [GAIN_W-1:0] div_gain;
  logic [PIX_W-1:0]  div_pix;

  rvig_div #(
    .DEN_W (NORM_W),
    .Q_W   (GAIN_W),
    .TAG_W (PIX_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vld_m2_q),
    .num_i   (num_m2_q),
    .den_i   (norm_q),
    .tag_i   (pix_m2_q),
    .valid_o (div_vld),
    .quot_o  (div_gain),
    .tag_o   (div_pix)
  );

  // ---------------- C1: scale and clamp each channel ----------------
  logic             vld_c1_q;
  logic [PIX_W-1:0] scaled_c1_q;
  logic [PIX_W-1:0] scaled_d;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [CH_W+GAIN_W-1:0] prod;
    logic [CH_W:0]          shifted;

    assign prod    = {{GAIN_W{1'b0}}, div_pix[c*CH_W +: CH_W]} * {{CH_W{1'b0}}, div_gain};
    assign shifted = prod[CH_W+GAIN_W-1:GAIN_FRAC];
    assign scaled_d[c*CH_W +: CH_W] = shifted[CH_W] ? '1 : shifted[CH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c1_q <= 1'b0;
    end else if (pipe_en) begin
      vld_c1_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      scaled_c1_q <= scaled_d;
    end
  end

  // ---------------- output register and skid entry ----------------
  logic [PIX_W-1:0] out_pix;

  rvig_obuf #(
    .W (PIX_W)
  ) u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_c1_q),
    .data_i      (scaled_c1_q),
    .en_o        (pipe_en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_pix)
  );

  assign blue_out_o  = out_pix[2*CH_W +: CH_W];
  assign green_out_o = out_pix[CH_W +: CH_W];
  assign red_out_o   = out_pix[0 +: CH_W];

  // ---------------- assertions ----------------
  a_num_within_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_m2_q |-> (num_m2_q <= norm_q))
    else $error("divider numerator above denominator");

  a_gain_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld |-> (div_gain <= (GAIN_W'(1) << GAIN_FRAC)))
    else $error("gain above 1.0");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_en && vld_c1_q) |=> (vld_c1_q && $stable(scaled_c1_q)))
    else $error("last stage moved while pipeline stalled");

endmodule
